// File: rtl/core/versioned_resource_id_parser_unit_macros.svh
// assertion helpers used by the rtl parser
`ifndef VERSIONED_RESOURCE_ID_PARSER_UNIT_MACROS_SVH
`define VERSIONED_RESOURCE_ID_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define VRP_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrp assertion failed");

// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrp assertion failed");

`endif

// File: rtl/core/vrp_pkg.sv
package vrp_pkg;

    // longest accepted name
    localparam int NAME_MAX   = 10;
    localparam int NAME_CNT_W = $clog2(NAME_MAX + 1);
    // fixed layout of the name fields on the result
    localparam int NAME_SLOTS = 10;

    // hex runs
    localparam int HEX_DIGITS = 7;
    localparam int POS_W      = 3;
    localparam int HASH_W     = 28;

    // characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_VEE     = 8'h76;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] VERSION_RESET = 8'h33;

    // output tdata width, whole bytes
    localparam int OUT_BITS   = 4 + 64 + 16 + HASH_W + HASH_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // parse phases
    typedef enum logic [9:0] {
        PH_NAME  = 10'b00_0000_0001,
        PH_HEX1  = 10'b00_0000_0010,
        PH_SEP1  = 10'b00_0000_0100,
        PH_HEX2  = 10'b00_0000_1000,
        PH_SEP2  = 10'b00_0001_0000,
        PH_VEE   = 10'b00_0010_0000,
        PH_VER   = 10'b00_0100_0000,
        PH_END   = 10'b00_1000_0000,
        PH_SLASH = 10'b01_0000_0000,
        PH_SUB   = 10'b10_0000_0000
    } phase_t;

    // one byte held in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } byte_beat_t;

    // one finished result
    typedef struct packed {
        logic              ok;
        logic [3:0]        name_length;
        logic [63:0]       name_low;
        logic [15:0]       name_high;
        logic [HASH_W-1:0] hash_first;
        logic [HASH_W-1:0] hash_second;
        logic              has_subpath;
    } result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b0, d[3:0]};
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = c - CH_LOWER_A + 8'd10;
            return {1'b0, d[3:0]};
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 8'd10;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

endpackage

// File: rtl/core/vrp_in_reg.sv
module vrp_in_reg
    import vrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       advance,
    output byte_beat_t beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       take;

    // the stage frees up when its byte moves on to the parser
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg <= s_axis_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.ch    = ch_reg;

endmodule

// File: rtl/core/vrp_parser.sv
`include "versioned_resource_id_parser_unit_macros.svh"

module vrp_parser
    import vrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] ch,
    input  logic [7:0] version_char,
    output result_t    res
);

    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [NAME_CNT_W-1:0] name_count_reg, name_count_next;
    logic [7:0]            name_reg [NAME_MAX];
    logic [7:0]            name_next [NAME_MAX];
    logic [HASH_W-1:0]     first_reg, first_next;
    logic [HASH_W-1:0]     second_reg, second_next;
    logic                  error_reg, error_next;
    logic                  sub_reg, sub_next;
    logic [4:0]            hex;
    logic                  end_of_string;
    logic                  ok;
    logic [8*NAME_SLOTS-1:0] name_flat;

    assign hex           = hex_value(ch);
    assign end_of_string = (ch == CH_NUL);

    // per-byte state update
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        name_count_next = name_count_reg;
        name_next       = name_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        error_next      = error_reg;
        sub_next        = sub_reg;
        if (step && end_of_string)
        begin
            // rearm for the next string
            phase_next      = PH_NAME;
            pos_next        = '0;
            name_count_next = '0;
            for (int i = 0; i < NAME_MAX; i++)
            begin
                name_next[i] = 8'h00;
            end
            first_next  = '0;
            second_next = '0;
            error_next  = 1'b0;
            sub_next    = 1'b0;
        end
        else if (step && !error_reg)
        begin
            case (phase_reg)
                PH_NAME:
                begin
                    if (ch == CH_UNDER)
                    begin
                        if (name_count_reg == '0)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HEX1;
                            pos_next   = '0;
                        end
                    end
                    else if (!is_alnum(ch) ||
                             name_count_reg >= NAME_CNT_W'(NAME_MAX))
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NAME_MAX; i++)
                        begin
                            if (name_count_reg == NAME_CNT_W'(i))
                            begin
                                name_next[i] = ch;
                            end
                        end
                        name_count_next = name_count_reg + 1'b1;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (hex[4])
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == PH_HEX1)
                        begin
                            first_next = {first_reg[HASH_W-5:0], hex[3:0]};
                        end
                        else
                        begin
                            second_next = {second_reg[HASH_W-5:0], hex[3:0]};
                        end
                        // last digit of the run moves to the separator
                        if (pos_reg == POS_W'(HEX_DIGITS - 1))
                        begin
                            pos_next   = '0;
                            phase_next = (phase_reg == PH_HEX1) ? PH_SEP1 : PH_SEP2;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                PH_SEP1:
                begin
                    if (ch == CH_UNDER) phase_next = PH_HEX2;
                    else                error_next = 1'b1;
                end
                PH_SEP2:
                begin
                    if (ch == CH_UNDER) phase_next = PH_VEE;
                    else                error_next = 1'b1;
                end
                PH_VEE:
                begin
                    if (ch == CH_VEE) phase_next = PH_VER;
                    else              error_next = 1'b1;
                end
                PH_VER:
                begin
                    if (ch == version_char) phase_next = PH_END;
                    else                    error_next = 1'b1;
                end
                PH_END:
                begin
                    if (ch == CH_SLASH) phase_next = PH_SLASH;
                    else                error_next = 1'b1;
                end
                PH_SLASH:
                begin
                    sub_next   = 1'b1;
                    phase_next = PH_SUB;
                end
                PH_SUB:
                begin
                    phase_next = PH_SUB;
                end
                default:
                begin
                    error_next = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NAME;
            pos_reg        <= '0;
            name_count_reg <= '0;
            error_reg      <= 1'b0;
            sub_reg        <= 1'b0;
            first_reg      <= '0;
            second_reg     <= '0;
            for (int i = 0; i < NAME_MAX; i++)
            begin
                name_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            name_count_reg <= name_count_next;
            error_reg      <= error_next;
            sub_reg        <= sub_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            name_reg       <= name_next;
        end
    end

    // name bytes laid out for the result, unused slots zero
    always_comb
    begin
        name_flat = '0;
        for (int i = 0; i < NAME_MAX; i++)
        begin
            name_flat[8*i +: 8] = name_reg[i];
        end
    end

    // result for the terminating byte, all zero on failure
    assign ok = !error_reg && (phase_reg == PH_END || phase_reg == PH_SUB);

    always_comb
    begin
        res = '0;
        if (ok)
        begin
            res.ok          = 1'b1;
            res.name_length = 4'(name_count_reg);
            res.name_low    = name_flat[63:0];
            res.name_high   = name_flat[79:64];
            res.hash_first  = first_reg;
            res.hash_second = second_reg;
            res.has_subpath = sub_reg;
        end
    end

    // checks
    `VRP_ASSERT(a_name_count_range, 1'b1, name_count_reg <= NAME_CNT_W'(NAME_MAX))
    `VRP_ASSERT(a_pos_range, 1'b1, pos_reg < POS_W'(HEX_DIGITS))
    `VRP_ASSERT_NEXT(a_error_sticky, error_reg && !(step && end_of_string), error_reg)
    `VRP_ASSERT_NEXT(a_rearm, step && end_of_string, phase_reg == PH_NAME && !error_reg && name_count_reg == '0 && !sub_reg)
    `VRP_ASSERT(a_fail_zero, !ok, res.name_low == '0 && res.hash_first == '0 && res.hash_second == '0 && !res.has_subpath)

endmodule

// File: rtl/core/versioned_resource_id_parser_unit.sv
// a NUL beat passes the input register, then the output register, before it shows as a result beat
// one input byte per cycle unless a NUL waits on a full output; the parser steps once per byte
// output register and input register let a new byte enter while a result waits
// reset (rst_n low, asynchronous): parse state cleared, version char set to '3'
module versioned_resource_id_parser_unit
    import vrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] ch
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] name_length, [67:4] name_low,
                                                  // [83:68] name_high, [111:84] hash_first,
                                                  // [139:112] hash_second, [140] has_subpath
    output logic                  m_axis_tuser,   // [0] ok
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    byte_beat_t beat;
    logic       advance;
    logic       load_out;
    result_t    res;
    logic [7:0] version_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    // version register write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            version_reg <= cfg_data;
        end
    end

    // a byte moves on unless it is a terminator facing a full output
    assign advance  = beat.valid &&
                      (beat.ch != CH_NUL || !out_valid_reg || m_axis_tready);
    assign load_out = advance && (beat.ch == CH_NUL);

    vrp_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .beat          (beat)
    );

    vrp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .ch           (beat.ch),
        .version_char (version_reg),
        .res          (res)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    // result beat packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.ok;
    assign m_axis_tdata  = {
        (OUT_DATA_W - OUT_BITS)'(0),
        out_reg.has_subpath,
        out_reg.hash_second,
        out_reg.hash_first,
        out_reg.name_high,
        out_reg.name_low,
        out_reg.name_length
    };

endmodule

// File: test/versioned_resource_id_parser_unit_tb.sv
module versioned_resource_id_parser_unit_tb;
    import vrp_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int RANDOM_BYTES   = 380;
    localparam int STALL_LIMIT    = 4000;
    localparam int LONG_HOLD      = 80;
    localparam int VERSION_STEPS  = 6;

    // parse predictor plus the queue of strings still waiting for their result
    class id_scoreboard;
        logic [7:0]        version;
        phase_t            phase;
        int unsigned       digits;
        int unsigned       name_len;
        logic [7:0]        name_chars[NAME_SLOTS];
        logic [HASH_W-1:0] first_hash;
        logic [HASH_W-1:0] second_hash;
        bit                broken;
        bit                subpath;
        result_t           expected_q[$];
        int                errors;
        int                results_seen;
        int                ok_seen;
        int                subpath_results;

        function new();
            version         = VERSION_RESET;
            errors          = 0;
            results_seen    = 0;
            ok_seen         = 0;
            subpath_results = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase       = PH_NAME;
            digits      = 0;
            name_len    = 0;
            first_hash  = '0;
            second_hash = '0;
            broken      = 1'b0;
            subpath     = 1'b0;
            foreach (name_chars[i])
                name_chars[i] = 8'h00;
        endfunction

        function bit letter_or_digit(input logic [7:0] c);
            return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                   (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                   (c >= CH_ZERO && c <= CH_NINE);
        endfunction

        // bit 4 flags a byte that is not a hex digit
        function logic [4:0] nibble_of(input logic [7:0] c);
            logic [7:0] n;
            n = 8'h10;
            if (c >= CH_ZERO && c <= CH_NINE)
                n = c - CH_ZERO;
            else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                n = c - CH_LOWER_A + 8'd10;
            else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                n = c - CH_UPPER_A + 8'd10;
            return n[4:0];
        endfunction

        function void shift_digit(input logic [7:0] c, inout logic [HASH_W-1:0] acc,
                                  input phase_t next_phase);
            logic [4:0] nib;
            nib = nibble_of(c);
            if (nib[4]) begin
                broken = 1'b1;
                return;
            end
            acc = {acc[HASH_W-5:0], nib[3:0]};
            digits++;
            if (digits >= HEX_DIGITS) begin
                digits = 0;
                phase  = next_phase;
            end
        endfunction

        function void consume(input logic [7:0] c);
            case (phase)
                PH_NAME:
                    if (c == CH_UNDER) begin
                        if (name_len == 0)
                            broken = 1'b1;
                        else begin
                            phase  = PH_HEX1;
                            digits = 0;
                        end
                    end else if (!letter_or_digit(c) || name_len >= NAME_MAX)
                        broken = 1'b1;
                    else begin
                        name_chars[name_len] = c;
                        name_len++;
                    end
                PH_HEX1:  shift_digit(c, first_hash, PH_SEP1);
                PH_SEP1:  if (c == CH_UNDER) phase = PH_HEX2; else broken = 1'b1;
                PH_HEX2:  shift_digit(c, second_hash, PH_SEP2);
                PH_SEP2:  if (c == CH_UNDER) phase = PH_VEE; else broken = 1'b1;
                PH_VEE:   if (c == CH_VEE) phase = PH_VER; else broken = 1'b1;
                PH_VER:   if (c == version) phase = PH_END; else broken = 1'b1;
                PH_END:   if (c == CH_SLASH) phase = PH_SLASH; else broken = 1'b1;
                PH_SLASH:
                begin
                    subpath = 1'b1;
                    phase   = PH_SUB;
                end
                PH_SUB:   ;
                default:  broken = 1'b1;
            endcase
        endfunction

        // one accepted input beat; a NUL closes the string and queues its result
        function void note_byte(input logic [7:0] c);
            result_t r;
            r = '0;
            if (c != CH_NUL) begin
                if (!broken)
                    consume(c);
                return;
            end
            if (!broken && (phase == PH_END || phase == PH_SUB)) begin
                r.ok          = 1'b1;
                r.name_length = name_len[3:0];
                for (int i = 0; i < 8; i++)
                    r.name_low[8*i +: 8] = name_chars[i];
                r.name_high   = {name_chars[9], name_chars[8]};
                r.hash_first  = first_hash;
                r.hash_second = second_hash;
                r.has_subpath = subpath;
            end
            expected_q.push_back(r);
            clear_parse();
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        // one accepted output beat against the oldest pending string
        task check_result(input logic [OUT_DATA_W-1:0] d, input logic ok_bit);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", d[63:0], 64'h0);
                return;
            end
            want = expected_q.pop_front();
            if (want.ok)
                ok_seen++;
            if (want.has_subpath)
                subpath_results++;
            if (ok_bit !== want.ok)
                report_mismatch("ok", 64'(ok_bit), 64'(want.ok));
            if (d[3:0] !== want.name_length)
                report_mismatch("name_length", 64'(d[3:0]), 64'(want.name_length));
            if (d[67:4] !== want.name_low)
                report_mismatch("name_low", d[67:4], want.name_low);
            if (d[83:68] !== want.name_high)
                report_mismatch("name_high", 64'(d[83:68]), 64'(want.name_high));
            if (d[111:84] !== want.hash_first)
                report_mismatch("hash_first", 64'(d[111:84]), 64'(want.hash_first));
            if (d[139:112] !== want.hash_second)
                report_mismatch("hash_second", 64'(d[139:112]), 64'(want.hash_second));
            if (d[140] !== want.has_subpath)
                report_mismatch("has_subpath", 64'(d[140]), 64'(want.has_subpath));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] ch
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [3:0] name_length, [67:4] name_low,
                                           // [83:68] name_high, [111:84] hash_first,
                                           // [139:112] hash_second, [140] has_subpath
    logic                  m_axis_tuser;   // [0] ok
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [7:0]            cfg_data;

    id_scoreboard sb;
    bit           gaps_on;
    bit           long_hold_req;
    int           bytes_sent;
    int           strings_sent;
    int           idle_cycles;

    versioned_resource_id_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("versioned_resource_id_parser_unit test failed");
        $finish;
    end

    // one byte beat, with an optional idle burst before it
    task automatic send_byte(input logic [7:0] c);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(c);
        bytes_sent++;
        if (c == CH_NUL)
            strings_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    // sender pauses until every pending result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        drain();
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.version = v;
    endtask

    function automatic logic [7:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(0, 2))
            0:       return CH_ZERO + 8'($urandom_range(0, 9));
            1:       return CH_LOWER_A + 8'($urandom_range(0, 5));
            default: return CH_UPPER_A + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // mostly well-formed ids with random content, some corrupted or truncated, a few pure noise
    task automatic send_random_id();
        logic [7:0] seq[$];
        int         kind;
        int         nlen;
        int         k;
        int         i;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 9) == 0)
                nlen = $urandom_range(NAME_MAX + 1, NAME_MAX + 3);
            else if ($urandom_range(0, 3) == 0)
                nlen = $urandom_range(1, NAME_MAX);
            else
                nlen = $urandom_range(1, 3);
            repeat (nlen) seq.push_back(pick_alnum());
            seq.push_back(CH_UNDER);
            repeat (HEX_DIGITS) seq.push_back(pick_hex());
            seq.push_back(CH_UNDER);
            repeat (HEX_DIGITS) seq.push_back(pick_hex());
            seq.push_back(CH_UNDER);
            seq.push_back(CH_VEE);
            seq.push_back(sb.version);
            if ($urandom_range(0, 2) == 0) begin
                seq.push_back(CH_SLASH);
                repeat ($urandom_range(0, 4)) seq.push_back(8'($urandom_range(1, 255)));
            end
            if (kind < 22) begin
                k = $urandom_range(0, seq.size() - 1);
                seq[k] = 8'($urandom_range(1, 255));
            end else if (kind < 32) begin
                k = $urandom_range(0, seq.size() - 1);
                while (seq.size() > k)
                    void'(seq.pop_back());
            end
        end
        for (i = 0; i < seq.size(); i++)
            send_byte(seq[i]);
        send_byte(CH_NUL);
    endtask

    initial
    begin
        logic [7:0] versions[VERSION_STEPS];
        int         step;
        int         base;
        sb            = new();
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        strings_sent  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        cfg_valid     <= 1'b0;
        cfg_data      <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings under the reset version character
        send_text("");
        send_text("_");
        send_text("a_");
        send_text("Az09_0123456_789abcd_v3");
        send_text("zzzzzzzzzZ_ABCDEFa_fffffff_v3/x/y");
        send_text("abcdefghijk_1111111_2222222_v3");
        send_text("n_0000000_FFFFFFF_v3/");
        send_text("n_000000g_0000000_v3");
        send_text("n_1234567_1234567_v3x");
        send_text("n_1234567-1234567_v3");
        send_text("n_1234567_1234567_w3");
        send_text("n_1234567_1234567_v4");

        // random ids across several version settings, extremes included
        versions[0] = VERSION_RESET;
        versions[1] = 8'hFF;
        versions[2] = 8'h00;
        versions[3] = 8'($urandom_range(1, 254));
        versions[4] = CH_SLASH;
        versions[5] = VERSION_RESET;
        base = bytes_sent;
        for (step = 0; step < VERSION_STEPS; step++)
        begin
            if (step > 0)
                write_version(versions[step]);
            gaps_on = (step != VERSION_STEPS - 1);
            if (step == 1) begin
                // output held off while input keeps coming, then a full drain
                long_hold_req = 1'b1;
                repeat (6) send_random_id();
                drain();
            end
            while (bytes_sent - base < (step + 1) * RANDOM_BYTES / VERSION_STEPS)
                send_random_id();
        end

        drain();
        repeat (RESULT_LATENCY + 4) @(posedge clk);
        $display("sent %0d bytes in %0d ids over %0d version settings",
                 bytes_sent, strings_sent, VERSION_STEPS);
        $display("checked %0d results: %0d parsed ok, %0d with subpath, %0d mismatches",
                 sb.results_seen, sb.ok_seen, sb.subpath_results, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("versioned_resource_id_parser_unit test passed");
        else
            $display("versioned_resource_id_parser_unit test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/vrp_pkg.sv
rtl/core/vrp_in_reg.sv
rtl/core/vrp_parser.sv
rtl/core/versioned_resource_id_parser_unit.sv
test/versioned_resource_id_parser_unit_tb.sv
